[hdl/erle_pkg.sv]
package erle_pkg;

    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);

    localparam logic [0:0] REG_ESCAPE    = 1'b0;
    localparam logic [7:0] ESCAPE_RESET  = 8'hBF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       item_last;
        logic       block_end;
    } out_item_t;

    typedef enum logic [1:0] {
        FLUSH_NONE,
        FLUSH_ONE,
        FLUSH_TWO,
        FLUSH_TRIPLE
    } flush_kind_t;

    // one command per input word that gives any output
    typedef struct packed {
        flush_kind_t flush_kind;
        logic [7:0]  flush_byte;
        logic [7:0]  flush_count;
        logic        close_block;
        logic [7:0]  close_byte;
        logic [7:0]  close_count;
    } cmd_t;

endpackage

[hdl/escape_byte_rle_encoder_unit.sv]
// Escape-byte run-length encoder.
// The first output byte for an input word is read from the command queue and held in the result register.
// Throughput: one input word per cycle while the four-entry command queue has room;
// the emitter puts out one byte per cycle while the result side keeps popping.
// Reset (rst_n low, asynchronous): run state and queues cleared, escape code to 0xBF.
module escape_byte_rle_encoder_unit
    import erle_pkg::*;
#(
    parameter int RUN_LIMIT = 254
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  in_item_t          item,
    output logic              empty,
    input  logic              pop,
    output out_item_t         result
);

    logic [7:0] escape_reg;
    logic       accept;
    cmd_t       front_cmd;
    logic       front_valid;
    cmd_t       head_cmd;
    logic       q_full;
    logic       q_empty;
    logic       head_done;
    logic       reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_ESCAPE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            escape_reg <= ESCAPE_RESET;
        else if (psel && penable && pwrite && reg_hit)
            escape_reg <= pwdata[7:0];
    end

    assign prdata = reg_hit ? {{(DATA_W-8){1'b0}}, escape_reg} : '0;

    assign full   = q_full;
    assign accept = push && !q_full;

    erle_front #(
        .RUN_LIMIT (RUN_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .escape_code (escape_reg),
        .cmd         (front_cmd),
        .cmd_valid   (front_valid)
    );

    erle_cmd_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_cmd),
        .rd_en   (head_done),
        .rd_data (head_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    erle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head_cmd),
        .cmd_valid   (!q_empty),
        .escape_code (escape_reg),
        .cmd_done    (head_done),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

[hdl/erle_front.sv]
module erle_front
    import erle_pkg::*;
#(
    parameter int RUN_LIMIT = 254
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  in_item_t   item,
    input  logic [7:0] escape_code,
    output cmd_t       cmd,
    output logic       cmd_valid
);

    localparam logic [7:0] LIMIT = 8'(RUN_LIMIT);

    logic [7:0] prev_reg, prev_next;
    logic [7:0] count_reg, count_next;
    logic       have_reg, have_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 8'd0;
            count_reg <= 8'd0;
            have_reg  <= 1'b0;
        end
        else if (accept)
        begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
            have_reg  <= have_next;
        end
    end

    always_comb
    begin
        logic is_esc;
        is_esc     = (prev_reg == escape_code);
        prev_next  = prev_reg;
        count_next = count_reg;
        have_next  = have_reg;
        cmd.flush_kind  = FLUSH_NONE;
        cmd.flush_byte  = prev_reg;
        cmd.flush_count = count_reg;

        priority if (!have_reg)
        begin
            prev_next  = item.in_byte;
            count_next = 8'd1;
            have_next  = 1'b1;
        end
        else if (item.in_byte == prev_reg)
        begin
            if (count_reg >= LIMIT)
            begin
                cmd.flush_kind = FLUSH_TRIPLE;
                count_next     = 8'd1;
            end
            else
            begin
                count_next = count_reg + 8'd1;
            end
        end
        else
        begin
            // run finished: short runs of ordinary bytes go out literally
            if (count_reg == 8'd1 && !is_esc)
                cmd.flush_kind = FLUSH_ONE;
            else if (count_reg == 8'd2 && !is_esc)
                cmd.flush_kind = FLUSH_TWO;
            else
                cmd.flush_kind = FLUSH_TRIPLE;
            prev_next  = item.in_byte;
            count_next = 8'd1;
        end

        cmd.close_block = item.in_last;
        cmd.close_byte  = prev_next;
        cmd.close_count = count_next;
        if (item.in_last)
        begin
            have_next  = 1'b0;
            count_next = 8'd0;
        end

        cmd_valid = accept && (cmd.flush_kind != FLUSH_NONE || item.in_last);
    end

endmodule

[hdl/erle_cmd_fifo.sv]
module erle_cmd_fifo
    import erle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic full,
    output logic empty
);

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W:0]   fill_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                fill_reg <= fill_reg + 1'b1;
            else if (rd_en && !wr_en)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign full    = (fill_reg == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign empty   = (fill_reg == '0);

endmodule

[hdl/erle_back.sv]
module erle_back
    import erle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cmd_valid,
    input  logic [7:0] escape_code,
    output logic       cmd_done,
    output out_item_t  result,
    output logic       empty,
    input  logic       pop
);

    logic [2:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    out_item_t  result_reg, result_next;
    logic       advance;
    logic [2:0] n_flush;
    logic [2:0] n_total;
    logic [2:0] close_step;
    logic [7:0] byte_sel;
    logic       is_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    always_comb
    begin
        unique case (cmd.flush_kind)
            FLUSH_NONE:   n_flush = 3'd0;
            FLUSH_ONE:    n_flush = 3'd1;
            FLUSH_TWO:    n_flush = 3'd2;
            FLUSH_TRIPLE: n_flush = 3'd3;
            default:      n_flush = 3'd0;
        endcase
        n_total    = n_flush + (cmd.close_block ? 3'd3 : 3'd0);
        close_step = step_reg - n_flush;

        if (step_reg < n_flush)
        begin
            if (cmd.flush_kind == FLUSH_TRIPLE)
            begin
                unique case (step_reg[1:0])
                    2'd0:    byte_sel = escape_code;
                    2'd1:    byte_sel = cmd.flush_byte;
                    default: byte_sel = cmd.flush_count;
                endcase
            end
            else
            begin
                byte_sel = cmd.flush_byte;
            end
        end
        else
        begin
            unique case (close_step[1:0])
                2'd0:    byte_sel = escape_code;
                2'd1:    byte_sel = cmd.close_byte;
                default: byte_sel = cmd.close_count;
            endcase
        end

        is_final = (step_reg == n_total - 3'd1);
        advance  = cmd_valid && (!valid_reg || pop);

        result_next.out_byte  = byte_sel;
        result_next.item_last = is_final;
        result_next.block_end = is_final && cmd.close_block;

        cmd_done  = advance && is_final;
        step_next = step_reg;
        if (advance)
            step_next = is_final ? 3'd0 : step_reg + 3'd1;

        if (advance)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    assign result = result_reg;
    assign empty  = !valid_reg;

endmodule

[test/erle_checker.sv]
`timescale 1ns / 1ps

module erle_checker
    import erle_pkg::*;
#(
    parameter int RUN_LIMIT = 254
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    input  logic              push,
    input  logic              full,
    input  in_item_t          item,
    input  logic              empty,
    input  logic              pop,
    input  out_item_t         result,
    output int                pending,
    output int                errors,
    output int                bytes_out,
    output int                blocks_closed,
    output int                limit_flushes
);

    logic [7:0] escape;
    logic [7:0] run_byte;
    logic [7:0] run_len;
    logic       run_open;
    out_item_t  coded_bytes[$];
    out_item_t  fresh[$];

    function automatic void emit(input logic [7:0] b);
        out_item_t w;
        w.out_byte  = b;
        w.item_last = 1'b0;
        w.block_end = 1'b0;
        fresh.push_back(w);
    endfunction

    function automatic void emit_triple(input logic [7:0] b, input logic [7:0] n);
        emit(escape);
        emit(b);
        emit(n);
    endfunction

    // expected compressed bytes for one accepted input word
    function automatic void encode_word(input in_item_t w);
        out_item_t tail;
        int        idx;
        fresh.delete();
        if (!run_open)
        begin
            run_byte = w.in_byte;
            run_len  = 8'd1;
            run_open = 1'b1;
        end
        else if (w.in_byte == run_byte)
        begin
            if (run_len >= RUN_LIMIT)
            begin
                emit_triple(run_byte, run_len);
                run_len = 8'd1;
                limit_flushes++;
            end
            else
                run_len = run_len + 8'd1;
        end
        else
        begin
            if (run_len == 8'd1 && run_byte != escape)
                emit(run_byte);
            else if (run_len == 8'd2 && run_byte != escape)
            begin
                emit(run_byte);
                emit(run_byte);
            end
            else
                emit_triple(run_byte, run_len);
            run_byte = w.in_byte;
            run_len  = 8'd1;
        end

        if (w.in_last)
        begin
            emit_triple(run_byte, run_len);
            idx = fresh.size() - 1;
            tail = fresh[idx];
            tail.block_end = 1'b1;
            fresh[idx] = tail;
            run_open = 1'b0;
            run_len  = 8'd0;
            blocks_closed++;
        end

        if (fresh.size() > 0)
        begin
            idx = fresh.size() - 1;
            tail = fresh[idx];
            tail.item_last = 1'b1;
            fresh[idx] = tail;
        end
        foreach (fresh[i])
            coded_bytes.push_back(fresh[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            escape        = ESCAPE_RESET;
            run_byte      = 8'd0;
            run_len       = 8'd0;
            run_open      = 1'b0;
            coded_bytes.delete();
            pending       = 0;
            errors        = 0;
            bytes_out     = 0;
            blocks_closed = 0;
            limit_flushes = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == ADDR_W'(REG_ESCAPE))
                escape = pwdata[7:0];

            if (push && !full)
                encode_word(item);

            if (pop && !empty)
            begin
                bytes_out++;
                if (coded_bytes.size() == 0)
                begin
                    $error("unexpected result word: out_byte %02h item_last %0b block_end %0b",
                           result.out_byte, result.item_last, result.block_end);
                    errors++;
                end
                else
                begin
                    want = coded_bytes.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, result.out_byte);
                        errors++;
                    end
                    if (result.item_last !== want.item_last)
                    begin
                        $error("item_last: expected %0b, got %0b",
                               want.item_last, result.item_last);
                        errors++;
                    end
                    if (result.block_end !== want.block_end)
                    begin
                        $error("block_end: expected %0b, got %0b",
                               want.block_end, result.block_end);
                        errors++;
                    end
                end
            end
            pending = coded_bytes.size();
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import erle_pkg::*;

    localparam int RUN_LIMIT    = 254;
    localparam int HOLD_AT      = 1;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_RUN     = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [ADDR_W-1:0] ESCAPE_ADDR = ADDR_W'(REG_ESCAPE) << 2;
    // first slot past the only register
    localparam logic [ADDR_W-1:0] VACANT_ADDR = ESCAPE_ADDR + ADDR_W'(4);

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push;
    logic              full;
    in_item_t          item;
    logic              empty;
    logic              pop;
    out_item_t         result;

    int         pending;
    int         errors;
    int         bytes_out;
    int         blocks_closed;
    int         limit_flushes;
    int         sent_count = 0;
    int         escape_writes = 0;
    int         cycles = 0;
    logic [7:0] escape_now = ESCAPE_RESET;

    escape_byte_rle_encoder_unit #(
        .RUN_LIMIT (RUN_LIMIT)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    erle_checker #(
        .RUN_LIMIT (RUN_LIMIT)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .item          (item),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .pending       (pending),
        .errors        (errors),
        .bytes_out     (bytes_out),
        .blocks_closed (blocks_closed),
        .limit_flushes (limit_flushes)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // result side: random pauses, bursts, and one long hold-off to back the block up
    initial
    begin : drain_side
        int popped;
        int gap;
        bit held;
        popped = 0;
        held   = 1'b0;
        pop    = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && sent_count >= HOLD_AT)
            begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            else if ((popped / 50) % 3 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            popped++;
            @(negedge clk);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        gap = ((sent_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push         <= 1'b1;
        item.in_byte <= b;
        item.in_last <= l;
        do @(posedge clk); while (full);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        // words that give no output may still be in flight
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_escape(input logic [7:0] value);
        drain();
        reg_write(ESCAPE_ADDR, value);
        escape_now = value;
        escape_writes++;
    endtask

    // skewed towards repeats, the escape byte and the extremes
    function automatic logic [7:0] pick_byte(input logic [7:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return prev;
        if (r < 50)
            return escape_now;
        if (r < 55)
            return 8'h00;
        if (r < 60)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic send_block(input int len, input bit close);
        logic [7:0] b;
        b = 8'($urandom);
        for (int i = 0; i < len; i++)
        begin
            b = pick_byte(b);
            send_word(b, close && i == len - 1);
        end
    endtask

    initial
    begin : stimulus
        int         n;
        int         len;
        logic [7:0] value;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        push         = 1'b0;
        item.in_byte = 8'h00;
        item.in_last = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single-byte block under the reset escape
        send_word(8'h00, 1'b1);
        // pair, single, lone escape, triple run, closing run
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(ESCAPE_RESET, 1'b0);
        send_word(8'h42, 1'b0);
        send_word(8'h42, 1'b0);
        send_word(8'h42, 1'b0);
        send_word(8'h00, 1'b1);
        // pair of the escape byte still becomes a triple
        send_word(ESCAPE_RESET, 1'b0);
        send_word(ESCAPE_RESET, 1'b0);
        send_word(8'h7E, 1'b1);

        set_escape(8'h00);
        drain();
        reg_write(VACANT_ADDR, 8'hFF);   // no register there, must leave escape alone
        send_word(8'h00, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h80, 1'b1);

        // escape changed while a run is open: the run becomes an escape run
        send_word(8'h55, 1'b0);
        send_word(8'h55, 1'b0);
        set_escape(8'h55);
        send_word(8'h56, 1'b1);

        set_escape(8'hFF);
        send_word(8'hFF, 1'b1);

        // a long run of one byte, closed by a different byte
        for (int i = 0; i < LONG_RUN; i++)
            send_word(8'h33, 1'b0);
        send_word(8'h34, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: value = 8'hFF;
                1: value = 8'h00;
                3: value = ESCAPE_RESET;
                default: value = 8'($urandom);
            endcase
            set_escape(value);
            if (ph == 2)
            begin
                drain();
                reg_write(VACANT_ADDR, 8'($urandom));
            end
            n = 0;
            while (n < 14)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20)
                                                  : $urandom_range(1, 12);
                // a few blocks are left open and run on into the next
                send_block(len, ph == 5 || $urandom_range(0, 4) != 0);
                n += len;
            end
        end
        send_word(pick_byte(escape_now), 1'b1);

        drain();
        $display("Run covered %0d input words and %0d output bytes in %0d closed blocks.",
                 sent_count, bytes_out, blocks_closed);
        $display("Escape set %0d times, %0d early flushes at the run limit of %0d.",
                 escape_writes, limit_flushes, RUN_LIMIT);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
